// ----- sv/mpss_pkg.sv -----
// Shared types and constants for the multi-pattern signature scan core.
package mpss_pkg;

  localparam int BYTE_W      = 8;
  localparam int NUM_SIGS    = 8;
  localparam int MAX_PATTERN = 32;

  typedef enum logic [1:0] {
    FUNC_PAT_WR  = 2'd0,
    FUNC_HDR_WR  = 2'd1,
    FUNC_SCAN    = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ----- sv/multi_pattern_signature_scan_core.sv -----
// Multi-pattern signature scan core: signature table, byte window and match logic.
//
// Takes one request per cycle, with no bubbles, as long as the result side keeps up.
// A request sits in an input register until it is taken. In that cycle all signatures are
// compared with the shifted byte window at once, and the table and window registers are
// updated. A scan's last byte writes max_severity/any_match into the output register and
// raises out_valid as it leaves the input register, which it does only when the output
// register is free. Pattern bytes are also kept pre-reversed, aligned to each signature's
// length. This keeps the per-byte compare at fixed comparator positions. A header write
// realigns the addressed row in the same cycle. Requests with func 3, and table writes
// beyond the table, change nothing. Only a scan-last request produces a result. The input
// side stalls only when the output register is full and stalled and a result is due.
module multi_pattern_signature_scan_core
  import mpss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [2:0] sig_index,
  input  logic [4:0] byte_pos,
  input  logic [7:0] data_byte,
  input  logic [5:0] pat_length,
  input  logic [7:0] severity,
  input  logic       active,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] max_severity,
  output logic       any_match
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  // input register
  logic       s1_valid;
  func_t      s1_func;
  logic [2:0] s1_sig_index;
  logic [4:0] s1_byte_pos;
  byte_t      s1_data_byte;
  logic [5:0] s1_pat_length;
  byte_t      s1_severity;
  logic       s1_active;
  logic       s1_last;

  // table and scan state
  byte_t             window   [MAX_PATTERN];
  logic [LEN_W-1:0]  scan_len;
  byte_t             pat_raw  [NUM_SIGS][MAX_PATTERN];
  byte_t             pat_algn [NUM_SIGS][MAX_PATTERN];
  logic [LEN_W-1:0]  sig_len  [NUM_SIGS];
  byte_t             sig_sev  [NUM_SIGS];
  logic [NUM_SIGS-1:0] sig_en;
  logic [NUM_SIGS-1:0] found;

  // datapath
  logic              in_accept;
  logic              s1_res;
  logic              s1_fire;
  logic              out_free;
  logic              do_pat, do_hdr, do_scan;
  byte_t             win_shift [MAX_PATTERN];
  logic [LEN_W-1:0]  scan_len_next;
  logic [NUM_SIGS-1:0] found_now;
  logic [NUM_SIGS-1:0] found_all;
  byte_t             best;
  logic [LEN_W-1:0]  hdr_len;
  byte_t             hdr_row   [MAX_PATTERN];
  byte_t             hdr_algn  [MAX_PATTERN];

  assign out_free  = !out_valid || !out_stall;
  assign s1_res    = (s1_func == FUNC_SCAN) && s1_last;
  assign s1_fire   = s1_valid && (!s1_res || out_free);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    do_pat  = 1'b0;
    do_hdr  = 1'b0;
    do_scan = 1'b0;
    unique case (s1_func)
      FUNC_PAT_WR: do_pat  = s1_fire;
      FUNC_HDR_WR: do_hdr  = s1_fire;
      FUNC_SCAN:   do_scan = s1_fire;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func        <= func_t'(func);
      s1_sig_index   <= sig_index;
      s1_byte_pos    <= byte_pos;
      s1_data_byte   <= data_byte;
      s1_pat_length  <= pat_length;
      s1_severity    <= severity;
      s1_active      <= active;
      s1_last        <= last;
    end
  end

  // window with the new byte shifted in at index 0
  always_comb begin
    win_shift[0] = s1_data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_shift[k] = window[k-1];
    end
    scan_len_next = (int'(scan_len) < MAX_PATTERN) ? scan_len + LEN_W'(1) : scan_len;
  end

  // one comparator row per signature, against the length-aligned pattern
  always_comb begin
    logic hit;
    for (int s = 0; s < NUM_SIGS; s++) begin
      hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if ((i < int'(sig_len[s])) && (win_shift[i] != pat_algn[s][i])) begin
          hit = 1'b0;
        end
      end
      found_now[s] = sig_en[s] && (sig_len[s] != '0) &&
                     (sig_len[s] <= scan_len_next) && hit;
    end
    found_all = found | found_now;
  end

  always_comb begin
    best = '0;
    for (int s = 0; s < NUM_SIGS; s++) begin
      if (found_all[s] && (sig_sev[s] > best)) begin
        best = sig_sev[s];
      end
    end
  end

  // header write: saturate length and realign the addressed row
  always_comb begin
    hdr_len = (int'(s1_pat_length) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                 : LEN_W'(s1_pat_length);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      hdr_row[j] = '0;
    end
    for (int s = 0; s < NUM_SIGS; s++) begin
      if (int'(s1_sig_index) == s) begin
        hdr_row = pat_raw[s];
      end
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      hdr_algn[i] = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (i + j + 1 == int'(hdr_len)) begin
          hdr_algn[i] = hdr_row[j];
        end
      end
    end
  end

  // pattern store, raw and aligned copies; no reset
  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_SIGS; s++) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (do_pat && (int'(s1_sig_index) == s)) begin
          if (int'(s1_byte_pos) == i) begin
            pat_raw[s][i] <= s1_data_byte;
          end
          if (i + int'(s1_byte_pos) + 1 == int'(sig_len[s])) begin
            pat_algn[s][i] <= s1_data_byte;
          end
        end else if (do_hdr && (int'(s1_sig_index) == s)) begin
          pat_algn[s][i] <= hdr_algn[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_en <= '0;
      for (int s = 0; s < NUM_SIGS; s++) begin
        sig_len[s] <= '0;
        sig_sev[s] <= '0;
      end
    end else if (do_hdr) begin
      for (int s = 0; s < NUM_SIGS; s++) begin
        if (int'(s1_sig_index) == s) begin
          sig_len[s] <= hdr_len;
          sig_sev[s] <= s1_severity;
          sig_en[s]  <= s1_active;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_len <= '0;
      found    <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window[k] <= '0;
      end
    end else if (do_scan) begin
      if (s1_last) begin
        scan_len <= '0;
        found    <= '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          window[k] <= '0;
        end
      end else begin
        scan_len <= scan_len_next;
        found    <= found_all;
        window   <= win_shift;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_res) begin
      max_severity <= best;
      any_match    <= (best != '0);
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_res && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_scan_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_res) |=> ((scan_len == '0) && (found == '0)))
    else $error("scan state not cleared after last byte");

  a_match_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (any_match == (max_severity != '0)))
    else $error("any_match disagrees with max_severity");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    int'(scan_len) <= MAX_PATTERN)
    else $error("scan length above window size");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the signature scan core: table loads and scans checked against a predictor.
module tb_top;
  import mpss_pkg::*;

  localparam int NSIG = 8;
  localparam int PLEN = 32;

  typedef struct {
    func_t      func;
    logic [2:0] sig_index;
    logic [4:0] byte_pos;
    byte_t      data_byte;
    logic [5:0] pat_length;
    byte_t      severity;
    logic       active;
    logic       last;
  } scan_req_t;

  typedef struct {
    byte_t max_sev;
    logic  any;
  } verdict_t;

  class scan_scoreboard;
    byte_t    window [PLEN];
    int       seen;
    byte_t    pat [NSIG][PLEN];
    int       len [NSIG];
    byte_t    sev [NSIG];
    bit       en [NSIG];
    bit       found [NSIG];
    verdict_t verdict_q [$];
    int       errors;

    function new();
      foreach (window[k]) window[k] = '0;
      foreach (pat[s, k]) pat[s][k] = '0;
      foreach (len[s]) begin
        len[s] = 0;
        sev[s] = '0;
        en[s] = 0;
        found[s] = 0;
      end
      seen = 0;
      errors = 0;
    endfunction

    // pattern byte 0 is the oldest byte of the matching tail
    function bit tail_hit(int s);
      for (int j = 0; j < len[s]; j++)
        if (pat[s][j] !== window[len[s] - 1 - j]) return 0;
      return 1;
    endfunction

    function void note_request(scan_req_t r);
      verdict_t v;
      case (r.func)
        FUNC_PAT_WR: pat[r.sig_index][r.byte_pos] = r.data_byte;
        FUNC_HDR_WR: begin
          len[r.sig_index] = (r.pat_length > PLEN) ? PLEN : int'(r.pat_length);
          sev[r.sig_index] = r.severity;
          en[r.sig_index] = r.active;
        end
        FUNC_SCAN: begin
          for (int k = PLEN - 1; k > 0; k--) window[k] = window[k - 1];
          window[0] = r.data_byte;
          if (seen < PLEN) seen++;
          for (int s = 0; s < NSIG; s++)
            if (en[s] && len[s] != 0 && len[s] <= seen && tail_hit(s)) found[s] = 1;
          if (r.last) begin
            v.max_sev = '0;
            for (int s = 0; s < NSIG; s++)
              if (found[s] && sev[s] > v.max_sev) v.max_sev = sev[s];
            v.any = (v.max_sev != 0);
            verdict_q.push_back(v);
            foreach (window[k]) window[k] = '0;
            foreach (found[s]) found[s] = 0;
            seen = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(byte_t ms, logic am);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("unexpected result: max_severity %0d any_match %0b", ms, am);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (ms !== v.max_sev) begin
        $error("max_severity: expected %0d, actual %0d", v.max_sev, ms);
        errors++;
      end
      if (am !== v.any) begin
        $error("any_match: expected %0b, actual %0b", v.any, am);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = '0;
  logic [2:0] sig_index = '0;
  logic [4:0] byte_pos = '0;
  logic [7:0] data_byte = '0;
  logic [5:0] pat_length = '0;
  logic [7:0] severity = '0;
  logic       active = 1'b0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] max_severity;
  logic       any_match;

  logic            hold_off = 1'b0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              item_count = 0;
  bit [PLEN-1:0]   loaded [NSIG];
  scan_scoreboard  sb = new();

  multi_pattern_signature_scan_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .sig_index(sig_index),
    .byte_pos(byte_pos),
    .data_byte(data_byte),
    .pat_length(pat_length),
    .severity(severity),
    .active(active),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .max_severity(max_severity),
    .any_match(any_match)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(max_severity, any_match);
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic scan_req_t rand_req(func_t f);
    scan_req_t r;
    r.func = f;
    r.sig_index = 3'($urandom);
    r.byte_pos = 5'($urandom);
    r.data_byte = byte_t'($urandom);
    r.pat_length = 6'($urandom);
    r.severity = byte_t'($urandom);
    r.active = 1'($urandom);
    r.last = 1'($urandom);
    return r;
  endfunction

  // narrow alphabet so patterns turn up in scans on their own
  function automatic byte_t alpha_byte();
    if ($urandom_range(3) == 0) return byte_t'($urandom);
    return byte_t'(8'h41 + $urandom_range(2));
  endfunction

  function automatic int pick_len();
    int c;
    c = $urandom_range(9);
    if (c == 0) return 0;
    if (c < 8) return $urandom_range(1, 6);
    return $urandom_range(7, 63);
  endfunction

  task automatic send_req(scan_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= r.func;
    sig_index <= r.sig_index;
    byte_pos <= r.byte_pos;
    data_byte <= r.data_byte;
    pat_length <= r.pat_length;
    severity <= r.severity;
    active <= r.active;
    last <= r.last;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    if (r.func == FUNC_PAT_WR) loaded[r.sig_index][r.byte_pos] = 1'b1;
    if (r.func != FUNC_UNUSED) item_count++;
  endtask

  task automatic write_pat(int s, int p, byte_t b);
    scan_req_t r;
    r = rand_req(FUNC_PAT_WR);
    r.sig_index = 3'(s);
    r.byte_pos = 5'(p);
    r.data_byte = b;
    send_req(r);
  endtask

  // an enabled signature must never compare a pattern byte that was not written
  task automatic write_hdr(int s, int plen, byte_t sv, bit act);
    scan_req_t r;
    int need;
    need = (plen > PLEN) ? PLEN : plen;
    if (act)
      for (int p = 0; p < need; p++)
        if (!loaded[s][p]) write_pat(s, p, alpha_byte());
    r = rand_req(FUNC_HDR_WR);
    r.sig_index = 3'(s);
    r.pat_length = 6'(plen);
    r.severity = sv;
    r.active = act;
    send_req(r);
  endtask

  task automatic scan_byte(byte_t b, bit lst);
    scan_req_t r;
    r = rand_req(FUNC_SCAN);
    r.data_byte = b;
    r.last = lst;
    send_req(r);
  endtask

  task automatic random_table_write();
    if ($urandom_range(2) == 0)
      write_hdr($urandom_range(NSIG - 1), pick_len(), byte_t'($urandom),
                $urandom_range(3) != 0);
    else
      write_pat($urandom_range(NSIG - 1), $urandom_range(PLEN - 1), alpha_byte());
  endtask

  task automatic run_scan();
    int n;
    int s;
    int at;
    byte_t bytes_q [$];
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 45) : $urandom_range(1, 12);
    for (int i = 0; i < n; i++) bytes_q.push_back(alpha_byte());
    // plant an enabled signature somewhere in the scan most of the time
    s = $urandom_range(NSIG - 1);
    if (sb.en[s] && sb.len[s] != 0 && sb.len[s] <= n && $urandom_range(3) != 0) begin
      at = $urandom_range(n - sb.len[s]);
      for (int j = 0; j < sb.len[s]; j++) bytes_q[at + j] = sb.pat[s][j];
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(24) == 0) random_table_write();
      if ($urandom_range(49) == 0) send_req(rand_req(FUNC_UNUSED));
      scan_byte(bytes_q[i], i == n - 1);
    end
  endtask

  task automatic hold_receiver(int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  task automatic run_phase(int s_idle, int r_stall, int items);
    int stop;
    send_idle_pct = s_idle;
    recv_stall_pct <= r_stall;
    stop = item_count + items;
    while (item_count < stop) begin
      case ($urandom_range(9))
        0, 1: random_table_write();
        2: send_req(rand_req(FUNC_UNUSED));
        default: run_scan();
      endcase
    end
  endtask

  initial begin
    scan_req_t r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table, ignored function code, zero length, zero severity
    scan_byte(8'h00, 1'b1);
    r = rand_req(FUNC_UNUSED);
    r.last = 1'b1;
    send_req(r);
    write_pat(7, 31, 8'hFF);
    write_pat(0, 0, 8'h41);
    write_pat(0, 1, 8'h42);
    write_hdr(0, 2, 8'hFF, 1'b1);
    write_pat(1, 0, 8'h00);
    write_hdr(1, 1, 8'h00, 1'b1);
    write_hdr(3, 0, 8'h80, 1'b1);
    write_hdr(2, 63, 8'h09, 1'b0);
    scan_byte(8'h41, 1'b0);
    scan_byte(8'h42, 1'b1);
    scan_byte(8'h00, 1'b1);
    // header rewritten mid-scan, then disabled after the hit
    scan_byte(8'h41, 1'b0);
    write_hdr(0, 2, 8'h07, 1'b1);
    scan_byte(8'h42, 1'b0);
    write_hdr(0, 2, 8'h07, 1'b0);
    scan_byte(8'hFF, 1'b1);
    write_hdr(0, 2, 8'h07, 1'b1);
    // a pattern split over two scans must not match
    scan_byte(8'h41, 1'b1);
    scan_byte(8'h42, 1'b1);

    // back-pressure: output held off while requests keep coming
    fork
      hold_receiver(400);
      for (int i = 0; i < 40; i++) scan_byte(alpha_byte(), 1'b1);
    join

    run_phase(0, 0, 250);
    run_phase(74, 0, 250);
    run_phase(0, 74, 250);
    run_phase(34, 34, 250);
    run_phase(0, 0, 250);

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && sb.verdict_q.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.verdict_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS multi_pattern_signature_scan_core");
    end else begin
      $display("FAIL multi_pattern_signature_scan_core");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL multi_pattern_signature_scan_core");
    $finish;
  end

endmodule
